/* hdl/keypad_matrix_wake_controller_unit_defines.svh */
// ----------------------------------------------------------------------------
// Keypad matrix wake controller: assertion macros
// Shared concurrent assertion forms for the checker of the controller.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_MATRIX_WAKE_CONTROLLER_UNIT_DEFINES_SVH
`define KEYPAD_MATRIX_WAKE_CONTROLLER_UNIT_DEFINES_SVH

// Checked at every rising edge once reset has been released.
`define KMW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define KMW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/kmw_pkg.sv */
// ----------------------------------------------------------------------------
// Keypad matrix wake controller package
// Key codes, model codes, the result record and the wake code table.
// ----------------------------------------------------------------------------
package kmw_pkg;

  localparam logic [5:0] KeyPower    = 6'h0f;
  localparam logic [5:0] KeySpecialA = 6'h25;
  localparam logic [5:0] KeySpecialB = 6'h35;
  localparam logic [5:0] KeyNoWake   = 6'h0e;
  localparam logic [5:0] WakeKeyLo   = 6'h08;
  localparam logic [5:0] WakeKeyHi   = 6'h0f;

  localparam logic [7:0] PowerMask   = 8'hfe;
  localparam logic [7:0] IoByteA     = 8'h55;
  localparam logic [7:0] IoByteB     = 8'h45;

  localparam int unsigned ResDepthDefault = 2;

  typedef enum logic [1:0] {
    MODEL_FIRST  = 2'd0,
    MODEL_SECOND = 2'd1,
    MODEL_THIRD  = 2'd2,
    MODEL_NONE   = 2'd3
  } model_e;

  typedef struct packed {
    logic [2:0] row_index;
    logic [7:0] row_bits;
    logic       scan_written;
    logic [2:0] scan_row;
    logic [2:0] scan_col;
    logic [7:0] io_key_byte;
    logic       io_key_written;
    logic       power_line;
    logic [3:0] wake_code;
    logic       wake_event;
    logic       asleep;
    logic       warm_reset_request;
  } res_t;

  // One result on its way from the event logic into the result queue.
  typedef struct packed {
    logic valid;
    res_t res;
  } res_beat_t;

  function automatic logic [3:0] wake_code_of(input logic [5:0] key);
    logic [3:0] code;
    case (key)
      6'h09:   code = 4'ha;
      6'h0a:   code = 4'h8;
      6'h0b:   code = 4'h6;
      6'h0c:   code = 4'h4;
      6'h0d:   code = 4'h2;
      default: code = 4'h0;
    endcase
    return code;
  endfunction

endpackage

/* hdl/kmw_intf.sv */
// ----------------------------------------------------------------------------
// Keypad matrix wake controller channels
// Valid/ready channels for key events and for result items.
// ----------------------------------------------------------------------------
interface kmw_key_if;
  logic       valid;
  logic       ready;
  logic [5:0] key_number;
  logic       pressed;

  modport source (output valid, output key_number, output pressed, input ready);
  modport sink   (input valid, input key_number, input pressed, output ready);
endinterface

interface kmw_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] row_index;
  logic [7:0] row_bits;
  logic       scan_written;
  logic [2:0] scan_row;
  logic [2:0] scan_col;
  logic [7:0] io_key_byte;
  logic       io_key_written;
  logic       power_line;
  logic [3:0] wake_code;
  logic       wake_event;
  logic       asleep;
  logic       warm_reset_request;

  modport source (
    output valid, output row_index, output row_bits, output scan_written,
    output scan_row, output scan_col, output io_key_byte, output io_key_written,
    output power_line, output wake_code, output wake_event, output asleep,
    output warm_reset_request, input ready
  );
  modport sink (
    input valid, input row_index, input row_bits, input scan_written,
    input scan_row, input scan_col, input io_key_byte, input io_key_written,
    input power_line, input wake_code, input wake_event, input asleep,
    input warm_reset_request, output ready
  );
endinterface

/* hdl/kmw_res_fifo.sv */
// ----------------------------------------------------------------------------
// Keypad matrix wake controller result queue
// Small first-in first-out buffer that holds finished result items.
// ----------------------------------------------------------------------------
module kmw_res_fifo #(
  parameter int unsigned Depth = kmw_pkg::ResDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kmw_pkg::res_beat_t beat_i,
  output logic               space_o,
  output logic               valid_o,
  output kmw_pkg::res_t      data_o,
  input  logic               ready_i
);
  import kmw_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  // The producer only pushes when space_o was high.
  assign push    = beat_i.valid;
  assign pop     = valid_o && ready_i;
  assign space_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= beat_i.res;
    end
  end

endmodule

/* hdl/kmw_core.sv */
// ----------------------------------------------------------------------------
// Keypad matrix wake controller event logic
// Input register, key state and the single-pass update for one key event.
// ----------------------------------------------------------------------------
module kmw_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [5:0]         key_number_i,
  input  logic               pressed_i,
  input  logic               space_i,
  output kmw_pkg::res_beat_t beat_o
);
  import kmw_pkg::*;

  logic       in_v_q, in_v_d;
  logic [5:0] key_q;
  logic       pressed_q;
  logic       accept, advance;

  model_e     model_q;
  logic [7:0] legacy_q [8];
  logic [7:0] legacy_d [8];
  logic       sleep_q, sleep_d;
  logic [3:0] wake_q, wake_d;
  logic [7:0] io_q, io_d;
  logic       pline_q, pline_d;
  res_t       res;

  assign advance = in_v_q && space_i;
  assign ready_o = !in_v_q || space_i;
  assign accept  = valid_i && ready_o;
  assign in_v_d  = accept ? 1'b1 : (advance ? 1'b0 : in_v_q);

  // The scan matrix itself is kept by the consumer; this block reports the
  // cell that each event writes.
  always_comb begin
    logic [2:0] row, col, srow, scol;
    logic [7:0] bits, new_row;
    logic       power, io_wr, wake_ev, warm, scan_wr;

    row     = key_q[2:0];
    col     = key_q[5:3];
    power   = (key_q == KeyPower);
    bits    = power ? PowerMask : (8'd1 << col);
    new_row = pressed_q ? (legacy_q[row] | bits) : (legacy_q[row] & ~bits);

    legacy_d = legacy_q;
    legacy_d[row] = new_row;

    io_d  = io_q;
    io_wr = 1'b0;
    if (!pressed_q) begin
      io_d  = '0;
      io_wr = 1'b1;
    end else if (key_q == KeySpecialA) begin
      io_d  = IoByteA;
      io_wr = 1'b1;
    end else if (key_q == KeySpecialB) begin
      io_d  = IoByteB;
      io_wr = 1'b1;
    end

    sleep_d = sleep_q;
    wake_d  = wake_q;
    wake_ev = 1'b0;
    if (pressed_q && sleep_q) begin
      if ((key_q inside {[WakeKeyLo:WakeKeyHi]}) && (key_q != KeyNoWake)) begin
        wake_d  = wake_code_of(key_q);
        wake_ev = 1'b1;
        sleep_d = 1'b0;
      end
    end else if (pressed_q && power) begin
      sleep_d = 1'b1;
    end

    // On the first model the power key has its own line instead of a cell.
    pline_d = pline_q;
    warm    = 1'b0;
    srow    = '0;
    scol    = '0;
    scan_wr = 1'b0;
    if (power && (model_q == MODEL_FIRST)) begin
      pline_d = !pressed_q;
      warm    = pressed_q;
    end else begin
      scan_wr = 1'b1;
      if (power && (model_q inside {MODEL_SECOND, MODEL_THIRD})) begin
        srow = '0;
        scol = '0;
      end else begin
        srow = row;
        scol = col;
      end
      warm = (model_q inside {MODEL_FIRST, MODEL_SECOND}) && (scol < 3'd2) && pressed_q;
    end

    res.row_index          = row;
    res.row_bits           = new_row;
    res.scan_written       = scan_wr;
    res.scan_row           = srow;
    res.scan_col           = scol;
    res.io_key_byte        = io_d;
    res.io_key_written     = io_wr;
    res.power_line         = pline_d;
    res.wake_code          = wake_d;
    res.wake_event         = wake_ev;
    res.asleep             = sleep_d;
    res.warm_reset_request = warm;
  end

  assign beat_o.valid = advance;
  assign beat_o.res   = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      model_q  <= MODEL_NONE;
      legacy_q <= '{default: '0};
      sleep_q  <= 1'b0;
      wake_q   <= '0;
      io_q     <= '0;
      pline_q  <= 1'b1;
    end else begin
      in_v_q <= in_v_d;
      if (cfg_we_i) begin
        model_q <= model_e'(cfg_wdata_i);
      end
      if (advance) begin
        legacy_q <= legacy_d;
        sleep_q  <= sleep_d;
        wake_q   <= wake_d;
        io_q     <= io_d;
        pline_q  <= pline_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q     <= key_number_i;
      pressed_q <= pressed_i;
    end
  end

endmodule

/* hdl/keypad_matrix_wake_controller_unit.sv */
// ----------------------------------------------------------------------------
// Keypad matrix wake controller
// Tracks key matrix, special-key byte, power line and sleep/wake per event.
// ----------------------------------------------------------------------------
// One key event is accepted in every cycle while key_i.ready is high, and each
// yields one result item: the event is captured in an input register,
// the matrix, sleep and power state are updated in one pass from there, and
// the result lands in a queue of ResDepth items. The rate is set only by the
// consumer: while the queue is full and the input register holds an event,
// key_i.ready is low. The machine model register may be written at any time
// the block is idle and takes effect for the next event.
module keypad_matrix_wake_controller_unit #(
  parameter int unsigned ResDepth = kmw_pkg::ResDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  kmw_key_if.sink          key_i,
  kmw_res_if.source        res_o
);
  import kmw_pkg::*;

  res_beat_t beat;
  logic      space;
  res_t      head;

  kmw_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .valid_i      (key_i.valid),
    .ready_o      (key_i.ready),
    .key_number_i (key_i.key_number),
    .pressed_i    (key_i.pressed),
    .space_i      (space),
    .beat_o       (beat)
  );

  kmw_res_fifo #(
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (beat),
    .space_o (space),
    .valid_o (res_o.valid),
    .data_o  (head),
    .ready_i (res_o.ready)
  );

  assign res_o.row_index          = head.row_index;
  assign res_o.row_bits           = head.row_bits;
  assign res_o.scan_written       = head.scan_written;
  assign res_o.scan_row           = head.scan_row;
  assign res_o.scan_col           = head.scan_col;
  assign res_o.io_key_byte        = head.io_key_byte;
  assign res_o.io_key_written     = head.io_key_written;
  assign res_o.power_line         = head.power_line;
  assign res_o.wake_code          = head.wake_code;
  assign res_o.wake_event         = head.wake_event;
  assign res_o.asleep             = head.asleep;
  assign res_o.warm_reset_request = head.warm_reset_request;

endmodule

/* hdl/kmw_checker.sv */
// ----------------------------------------------------------------------------
// Keypad matrix wake controller checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "keypad_matrix_wake_controller_unit_defines.svh"

module kmw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic res_valid_i,
  input logic res_ready_i,
  input logic scan_written_i,
  input logic power_line_i,
  input logic wake_event_i,
  input logic asleep_i,
  input logic warm_reset_request_i
);

  // A result may not be withdrawn before it is taken.
  `KMW_ASSERT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i |=> res_valid_i, "result dropped while stalled")

  `KMW_ASSERT_ALWAYS(a_no_res_in_reset, clk_i, !rst_ni |=> !res_valid_i, "result shown during reset")

  // A power key press on the first model pulls the line and requests reset.
  `KMW_ASSERT(a_power_line, clk_i, rst_ni, res_valid_i && warm_reset_request_i && !scan_written_i |-> !power_line_i, "power line high on power key press")

  `KMW_ASSERT(a_wake_awake, clk_i, rst_ni, res_valid_i && wake_event_i |-> !asleep_i, "still asleep after wake event")

endmodule

bind keypad_matrix_wake_controller_unit kmw_checker u_kmw_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .res_valid_i          (res_o.valid),
  .res_ready_i          (res_o.ready),
  .scan_written_i       (res_o.scan_written),
  .power_line_i         (res_o.power_line),
  .wake_event_i         (res_o.wake_event),
  .asleep_i             (res_o.asleep),
  .warm_reset_request_i (res_o.warm_reset_request)
);
